@@ rtl/arrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arrb_pkg;

    localparam int DEPTH_BYTES_DEF = 2048;
    localparam int BLOCK_BYTES_DEF = 512;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 64;
    localparam int FILL_W = 12;
    localparam int REC_LEN = 6;

    localparam logic [OP_W-1:0] OP_REC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RAW   = 2'd1;
    localparam logic [OP_W-1:0] OP_GET   = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // record byte select, counted down from the tag to the carriage return
    localparam logic [2:0] SEL_TAG   = 3'd5;
    localparam logic [2:0] SEL_SPACE = 3'd4;
    localparam logic [2:0] SEL_HUND  = 3'd3;
    localparam logic [2:0] SEL_TENS  = 3'd2;
    localparam logic [2:0] SEL_UNIT  = 3'd1;
    localparam logic [2:0] SEL_CR    = 3'd0;

    typedef struct packed {
        logic       load;
        logic       wr;
        logic       rd;
        logic       emit;
        logic       word;
        logic       last;
        logic       drop;
        logic       flush;
        logic [2:0] sel;
    } t_cmd;

    typedef struct packed {
        logic rec_room;
        logic byte_room;
        logic blk_avail;
        logic out_free;
    } t_stat;

    // hundreds, tens, units of a byte as three nibbles
    function automatic logic [11:0] dec_digits(input logic [BYTE_W-1:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  u;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 2'd0;
            r = v[6:0];
        end
        // r below 100: r * 205 / 2048 is r / 10
        p = 15'(r) * 15'd205;
        t = p[14:11];
        u = 4'(r - 7'(t) * 7'd10);
        return {2'b00, h, t, u};
    endfunction

endpackage

`default_nettype wire

@@ rtl/arrb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface arrb_in_if;
    logic                               valid;
    logic                               ready;
    logic [arrb_pkg::OP_W-1:0]          opcode;
    logic [arrb_pkg::BYTE_W-1:0]        value;
    logic [arrb_pkg::BYTE_W-1:0]        tag;

    modport source (output valid, output opcode, output value, output tag, input ready);
    modport sink   (input valid, input opcode, input value, input tag, output ready);
endinterface

interface arrb_out_if;
    logic                               valid;
    logic                               ready;
    logic [arrb_pkg::WORD_W-1:0]        data_word;
    logic                               last;
    logic                               block_ok;
    logic                               dropped;
    logic [arrb_pkg::FILL_W-1:0]        fill_level;
    logic                               is_empty;
    logic                               is_full;

    modport source (output valid, output data_word, output last, output block_ok,
                    output dropped, output fill_level, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input data_word, input last, input block_ok,
                    input dropped, input fill_level, input is_empty, input is_full,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/arrb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/arrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arrb_ctrl #(
    parameter int BLOCK_BYTES = arrb_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [arrb_pkg::OP_W-1:0]     i_opcode,
    input  wire arrb_pkg::t_stat               i_stat,
    output logic                               o_in_ready,
    output arrb_pkg::t_cmd                     o_cmd
);

    localparam int BW  = BLOCK_BYTES / 8;
    localparam int WCW = (BW > 1) ? $clog2(BW) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUT   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WLAST = 3'd3;
    localparam logic [2:0] S_WOUT  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]     r_state, n_state;
    logic [2:0]     r_cnt, n_cnt;
    logic [WCW-1:0] r_wcnt, n_wcnt;
    logic           r_drop, n_drop;
    logic           w_wlast;

    assign w_wlast = (r_wcnt == WCW'(BW - 1));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_wcnt     = r_wcnt;
        n_drop     = r_drop;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_drop     = 1'b0;
                    case (i_opcode)
                        arrb_pkg::OP_REC: begin
                            if (i_stat.rec_room) begin
                                n_cnt   = arrb_pkg::SEL_TAG;
                                n_state = S_PUT;
                            end else begin
                                n_drop  = 1'b1;
                                n_state = S_RESP;
                            end
                        end
                        arrb_pkg::OP_RAW: begin
                            if (i_stat.byte_room) begin
                                n_cnt   = arrb_pkg::SEL_CR;
                                n_state = S_PUT;
                            end else begin
                                n_drop  = 1'b1;
                                n_state = S_RESP;
                            end
                        end
                        arrb_pkg::OP_GET: begin
                            if (i_stat.blk_avail) begin
                                n_cnt   = 3'd7;
                                n_wcnt  = '0;
                                n_state = S_RD;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        arrb_pkg::OP_FLUSH: begin
                            o_cmd.flush = 1'b1;
                            n_state     = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PUT: begin
                o_cmd.wr  = 1'b1;
                o_cmd.sel = r_cnt;
                if (r_cnt == 3'd0) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (r_cnt == 3'd0) begin
                    n_state = S_WLAST;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_WLAST: begin
                n_state = S_WOUT;
            end
            S_WOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.word = 1'b1;
                    o_cmd.last = w_wlast;
                    if (w_wlast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_wcnt  = r_wcnt + 1'b1;
                        n_cnt   = 3'd7;
                        n_state = S_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.drop = r_drop;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wcnt  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wcnt  <= n_wcnt;
            r_drop  <= n_drop;
        end
    end

endmodule

`default_nettype wire

@@ rtl/arrb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arrb_dp #(
    parameter int DEPTH_BYTES = arrb_pkg::DEPTH_BYTES_DEF,
    parameter int BLOCK_BYTES = arrb_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire arrb_pkg::t_cmd                i_cmd,
    input  wire logic [arrb_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [arrb_pkg::BYTE_W-1:0]   i_value,
    input  wire logic [arrb_pkg::BYTE_W-1:0]   i_tag,
    input  wire logic                          i_out_ready,
    output arrb_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic [arrb_pkg::WORD_W-1:0]        o_data_word,
    output logic                               o_last,
    output logic                               o_block_ok,
    output logic                               o_dropped,
    output logic [arrb_pkg::FILL_W-1:0]        o_fill_level,
    output logic                               o_is_empty,
    output logic                               o_is_full
);

    localparam int PW = $clog2(DEPTH_BYTES);
    localparam int HW = $clog2(DEPTH_BYTES + 1);
    localparam int BLK = (BLOCK_BYTES / 8) * 8;

    logic [PW-1:0]                   r_wp, n_wp;
    logic [PW-1:0]                   r_rp, n_rp;
    logic [HW-1:0]                   r_held, n_held;
    logic [arrb_pkg::OP_W-1:0]       r_op;
    logic [arrb_pkg::BYTE_W-1:0]     r_val;
    logic [arrb_pkg::BYTE_W-1:0]     r_tag;
    logic [11:0]                     r_dig;
    logic [arrb_pkg::WORD_W-1:0]     r_word;
    logic                            r_rd_pend;
    logic [arrb_pkg::BYTE_W-1:0]     w_wbyte;
    logic [arrb_pkg::BYTE_W-1:0]     w_rbyte;

    logic                            r_out_valid;
    logic [arrb_pkg::WORD_W-1:0]     r_out_word;
    logic                            r_out_last;
    logic                            r_out_ok;
    logic                            r_out_drop;
    logic [arrb_pkg::FILL_W-1:0]     r_out_fill;
    logic                            r_out_empty;
    logic                            r_out_full;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == PW'(DEPTH_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (r_op == arrb_pkg::OP_RAW) begin
            w_wbyte = r_val;
        end else begin
            case (i_cmd.sel)
                arrb_pkg::SEL_TAG:   w_wbyte = r_tag;
                arrb_pkg::SEL_SPACE: w_wbyte = arrb_pkg::CH_SPACE;
                arrb_pkg::SEL_HUND:  w_wbyte = arrb_pkg::CH_ZERO | {4'd0, r_dig[11:8]};
                arrb_pkg::SEL_TENS:  w_wbyte = arrb_pkg::CH_ZERO | {4'd0, r_dig[7:4]};
                arrb_pkg::SEL_UNIT:  w_wbyte = arrb_pkg::CH_ZERO | {4'd0, r_dig[3:0]};
                default:             w_wbyte = arrb_pkg::CH_CR;
            endcase
        end
    end

    arrb_ram #(
        .WIDTH (arrb_pkg::BYTE_W),
        .DEPTH (DEPTH_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_wp),
        .i_wdata (w_wbyte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rp),
        .o_rdata (w_rbyte)
    );

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_held = r_held;
        if (i_cmd.flush) begin
            n_wp   = '0;
            n_rp   = '0;
            n_held = '0;
        end else begin
            if (i_cmd.wr) begin
                n_wp   = adv(r_wp);
                n_held = r_held + 1'b1;
            end
            if (i_cmd.rd) begin
                n_rp = adv(r_rp);
            end
            if (i_cmd.emit && i_cmd.word) begin
                n_held = r_held - HW'(8);
            end
        end
    end

    assign o_stat.rec_room  = (r_held <= HW'(DEPTH_BYTES - arrb_pkg::REC_LEN));
    assign o_stat.byte_room = (r_held < HW'(DEPTH_BYTES));
    assign o_stat.blk_avail = (BLK >= 8) && (r_held >= HW'(BLK));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_held      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_held    <= n_held;
            r_rd_pend <= i_cmd.rd;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item fields, read assembly and the result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_val <= i_value;
            r_tag <= i_tag;
            r_dig <= arrb_pkg::dec_digits(i_value);
        end
        if (r_rd_pend) begin
            r_word <= {w_rbyte, r_word[arrb_pkg::WORD_W-1:arrb_pkg::BYTE_W]};
        end
        if (i_cmd.emit) begin
            r_out_word  <= i_cmd.word ? r_word : '0;
            r_out_last  <= i_cmd.last;
            r_out_ok    <= i_cmd.word;
            r_out_drop  <= i_cmd.drop;
            r_out_fill  <= arrb_pkg::FILL_W'(n_held);
            r_out_empty <= (n_held == '0);
            r_out_full  <= (n_held >= HW'(DEPTH_BYTES));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_word  = r_out_word;
    assign o_last       = r_out_last;
    assign o_block_ok   = r_out_ok;
    assign o_dropped    = r_out_drop;
    assign o_fill_level = r_out_fill;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;

endmodule

`default_nettype wire

@@ rtl/ascii_record_ring_buffer.sv @@
// channel   dir  payload                                            role
// i_in      in   opcode, value, tag                                 put, get, flush requests
// o_out     out  data_word, last, block_ok, dropped, fill_level,    results, one per transfer
//                is_empty, is_full
//
// one item in flight: the next item is taken only after the last result of the current one is loaded
// a block get reads each 8-byte word byte by byte, 64 words at the default size,
// paced by the single byte-wide read port of the store
// synchronous active-low reset clears pointers and count; the store is not cleared
// the result register frees the input side while a result waits; a stalled
// output only holds back the next result, of the same item or of the next
`timescale 1ns / 1ps
`default_nettype none

module ascii_record_ring_buffer #(
    parameter int DEPTH_BYTES = arrb_pkg::DEPTH_BYTES_DEF,
    parameter int BLOCK_BYTES = arrb_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    arrb_in_if.sink     i_in,
    arrb_out_if.source  o_out
);

    arrb_pkg::t_cmd  w_cmd;
    arrb_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign i_in.ready = w_in_ready;

    arrb_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    arrb_dp #(
        .DEPTH_BYTES (DEPTH_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_opcode     (i_in.opcode),
        .i_value      (i_in.value),
        .i_tag        (i_in.tag),
        .i_out_ready  (o_out.ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_out.valid),
        .o_data_word  (o_out.data_word),
        .o_last       (o_out.last),
        .o_block_ok   (o_out.block_ok),
        .o_dropped    (o_out.dropped),
        .o_fill_level (o_out.fill_level),
        .o_is_empty   (o_out.is_empty),
        .o_is_full    (o_out.is_full)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is still in work");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.block_ok) |-> (o_out.data_word == '0))
        else $error("nonzero data word outside a block");

    a_ok_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.block_ok) |-> !o_out.dropped)
        else $error("block word flagged as dropped");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.is_empty && o_out.is_full))
        else $error("result both empty and full");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result loaded over one not yet taken");
`endif

endmodule

`default_nettype wire

@@ sim/tb_ascii_record_ring_buffer.sv @@
`timescale 1ns / 1ps

module tb_ascii_record_ring_buffer;

    localparam int DEPTH       = arrb_pkg::DEPTH_BYTES_DEF;
    localparam int BLOCK_WORDS = arrb_pkg::BLOCK_BYTES_DEF / 8;
    localparam int PTR_W       = $clog2(DEPTH);

    typedef struct packed {
        logic [arrb_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        ok;
        logic                        drop;
        logic [arrb_pkg::FILL_W-1:0] fill;
        logic                        empty;
        logic                        full;
    } t_log_result;

    // directed row: request, then a typed-in single result where typed is set
    typedef struct packed {
        logic [arrb_pkg::OP_W-1:0]   op;
        logic [arrb_pkg::BYTE_W-1:0] val;
        logic [arrb_pkg::BYTE_W-1:0] tag;
        logic                        typed;
        logic                        drop;
        logic [arrb_pkg::FILL_W-1:0] fill;
        logic                        empty;
        logic                        full;
    } t_dir_row;

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        {arrb_pkg::OP_GET,   8'h00, 8'h00, 1'b1, 1'b0, 12'd0,  1'b1, 1'b0},
        {arrb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b1, 1'b0, 12'd0,  1'b1, 1'b0},
        {arrb_pkg::OP_RAW,   8'h00, 8'h00, 1'b1, 1'b0, 12'd1,  1'b0, 1'b0},
        {arrb_pkg::OP_RAW,   8'hFF, 8'hFF, 1'b1, 1'b0, 12'd2,  1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'h00, 8'h00, 1'b1, 1'b0, 12'd8,  1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'hFF, 8'hFF, 1'b1, 1'b0, 12'd14, 1'b0, 1'b0},
        {arrb_pkg::OP_GET,   8'hFF, 8'h00, 1'b1, 1'b0, 12'd14, 1'b0, 1'b0},
        {arrb_pkg::OP_FLUSH, 8'hFF, 8'hFF, 1'b1, 1'b0, 12'd0,  1'b1, 1'b0},
        {arrb_pkg::OP_REC,   8'd100, 8'h41, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd99,  8'h80, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd9,   8'h7F, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd10,  8'h01, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd199, 8'hC3, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd200, 8'h3C, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd55,  8'hAA, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_RAW,   8'hAA,  8'h55, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_RAW,   8'h55,  8'hAA, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_GET,   8'h00,  8'h00, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_RAW,   8'h01,  8'h80, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
        {arrb_pkg::OP_REC,   8'd128, 8'hFE, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    arrb_in_if  in_ch ();
    arrb_out_if out_ch ();

    ascii_record_ring_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [arrb_pkg::BYTE_W-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]            ring_wr;
    logic [PTR_W-1:0]            ring_rd;
    int                          ring_held;

    t_log_result expected_results [$];
    int          err_count;
    bit          src_idle_on;
    bit          snk_idle_on;
    int          snk_hold;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] exp_v);
        $display("mismatch on %s at %0t: got %h expected %h", what, $realtime, got_v, exp_v);
        err_count++;
    endtask

    task automatic push_result(input logic [arrb_pkg::WORD_W-1:0] w, input logic lst,
                               input logic ok, input logic drp);
        t_log_result r;
        r.word  = w;
        r.last  = lst;
        r.ok    = ok;
        r.drop  = drp;
        r.fill  = ring_held[arrb_pkg::FILL_W-1:0];
        r.empty = (ring_held == 0);
        r.full  = (ring_held >= DEPTH);
        expected_results.push_back(r);
    endtask

    task automatic ring_put(input logic [arrb_pkg::BYTE_W-1:0] b);
        ring_mem[ring_wr] = b;
        ring_wr = ring_wr + 1'b1;
        ring_held++;
    endtask

    task automatic ring_model_apply(input logic [arrb_pkg::OP_W-1:0] op,
                                    input logic [arrb_pkg::BYTE_W-1:0] val,
                                    input logic [arrb_pkg::BYTE_W-1:0] tag);
        logic [arrb_pkg::WORD_W-1:0] w;
        if (op == arrb_pkg::OP_REC) begin
            if (DEPTH - ring_held < arrb_pkg::REC_LEN) begin
                push_result('0, 1'b1, 1'b0, 1'b1);
            end else begin
                ring_put(tag);
                ring_put(arrb_pkg::CH_SPACE);
                ring_put(arrb_pkg::CH_ZERO + arrb_pkg::BYTE_W'(val / 100));
                ring_put(arrb_pkg::CH_ZERO + arrb_pkg::BYTE_W'((val / 10) % 10));
                ring_put(arrb_pkg::CH_ZERO + arrb_pkg::BYTE_W'(val % 10));
                ring_put(arrb_pkg::CH_CR);
                push_result('0, 1'b1, 1'b0, 1'b0);
            end
        end else if (op == arrb_pkg::OP_RAW) begin
            if (ring_held >= DEPTH) begin
                push_result('0, 1'b1, 1'b0, 1'b1);
            end else begin
                ring_put(val);
                push_result('0, 1'b1, 1'b0, 1'b0);
            end
        end else if (op == arrb_pkg::OP_GET) begin
            if (ring_held < BLOCK_WORDS * 8) begin
                push_result('0, 1'b1, 1'b0, 1'b0);
            end else begin
                for (int k = 0; k < BLOCK_WORDS; k++) begin
                    for (int b = 0; b < 8; b++) begin
                        w[8*b +: 8] = ring_mem[ring_rd];
                        ring_rd = ring_rd + 1'b1;
                    end
                    ring_held -= 8;
                    push_result(w, k == BLOCK_WORDS - 1, 1'b1, 1'b0);
                end
            end
        end else begin
            ring_wr   = '0;
            ring_rd   = '0;
            ring_held = 0;
            push_result('0, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic sender_gap();
        int n;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic put_item(input logic [arrb_pkg::OP_W-1:0] op,
                            input logic [arrb_pkg::BYTE_W-1:0] val,
                            input logic [arrb_pkg::BYTE_W-1:0] tag);
        sender_gap();
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= val;
        in_ch.tag    <= tag;
        do @(posedge i_clk); while (!in_ch.ready);
        ring_model_apply(op, val, tag);
    endtask

    task automatic random_item(input int rec_pct, input int raw_pct, input int get_pct);
        int r;
        logic [arrb_pkg::OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < rec_pct) op = arrb_pkg::OP_REC;
        else if (r < rec_pct + raw_pct) op = arrb_pkg::OP_RAW;
        else if (r < rec_pct + raw_pct + get_pct) op = arrb_pkg::OP_GET;
        else op = arrb_pkg::OP_FLUSH;
        put_item(op, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                 arrb_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // result sink with random stall bursts
    always @(negedge i_clk) begin
        if (snk_idle_on && snk_hold > 0) begin
            snk_hold     <= snk_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
            snk_hold     <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_log_result got;
        t_log_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.word  = out_ch.data_word;
            got.last  = out_ch.last;
            got.ok    = out_ch.block_ok;
            got.drop  = out_ch.dropped;
            got.fill  = out_ch.fill_level;
            got.empty = out_ch.is_empty;
            got.full  = out_ch.is_full;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", got.word, '0);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.word !== exp_r.word) report_mismatch("data_word", got.word, exp_r.word);
                if (got.last !== exp_r.last) report_mismatch("last", got.last, exp_r.last);
                if (got.ok !== exp_r.ok) report_mismatch("block_ok", got.ok, exp_r.ok);
                if (got.drop !== exp_r.drop) report_mismatch("dropped", got.drop, exp_r.drop);
                if (got.fill !== exp_r.fill) report_mismatch("fill_level", got.fill, exp_r.fill);
                if (got.empty !== exp_r.empty) report_mismatch("is_empty", got.empty, exp_r.empty);
                if (got.full !== exp_r.full) report_mismatch("is_full", got.full, exp_r.full);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_log_result typed_r;
        int n;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.opcode = arrb_pkg::OP_REC;
        in_ch.value  = '0;
        in_ch.tag    = '0;
        out_ch.ready = 1'b0;
        snk_hold     = 0;
        err_count    = 0;
        ring_wr      = '0;
        ring_rd      = '0;
        ring_held    = 0;
        src_idle_on  = 1'b1;
        snk_idle_on  = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            put_item(DIRECTED[i].op, DIRECTED[i].val, DIRECTED[i].tag);
            if (DIRECTED[i].typed) begin
                typed_r       = '0;
                typed_r.last  = 1'b1;
                typed_r.drop  = DIRECTED[i].drop;
                typed_r.fill  = DIRECTED[i].fill;
                typed_r.empty = DIRECTED[i].empty;
                typed_r.full  = DIRECTED[i].full;
                void'(expected_results.pop_back());
                expected_results.push_back(typed_r);
            end
        end

        // mixed traffic, no flush so the pointers keep moving
        repeat (40) random_item(60, 30, 10);

        // fill up to the last record that fits, overflow it, then fill with raw bytes and overflow again
        n = 0;
        while (DEPTH - ring_held >= arrb_pkg::REC_LEN) begin
            if (n % 64 == 0) src_idle_on = $urandom_range(0, 1);
            snk_idle_on = src_idle_on || (n % 128 < 64);
            if ($urandom_range(0, 9) == 0)
                put_item(arrb_pkg::OP_RAW, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                         arrb_pkg::BYTE_W'($urandom_range(0, 255)));
            else
                put_item(arrb_pkg::OP_REC, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                         arrb_pkg::BYTE_W'($urandom_range(0, 255)));
            n++;
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        put_item(arrb_pkg::OP_REC, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                 arrb_pkg::BYTE_W'($urandom_range(0, 255)));
        while (ring_held < DEPTH)
            put_item(arrb_pkg::OP_RAW, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                     arrb_pkg::BYTE_W'($urandom_range(0, 255)));
        repeat (2)
            put_item(arrb_pkg::OP_RAW, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                     arrb_pkg::BYTE_W'($urandom_range(0, 255)));
        put_item(arrb_pkg::OP_REC, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                 arrb_pkg::BYTE_W'($urandom_range(0, 255)));
        wait_results_drained();

        // drain the full buffer block by block, then one get too many
        while (ring_held >= BLOCK_WORDS * 8)
            put_item(arrb_pkg::OP_GET, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                     arrb_pkg::BYTE_W'($urandom_range(0, 255)));
        put_item(arrb_pkg::OP_GET, arrb_pkg::BYTE_W'($urandom_range(0, 255)),
                 arrb_pkg::BYTE_W'($urandom_range(0, 255)));

        // final stretch without idling
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        repeat (40) random_item(50, 30, 12);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results still pending", expected_results.size(), 0);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
